@@ sv/sqvs_pkg.sv @@
// ----------------------------------------------------------------------------
// sqvs_pkg
// Shared types, codes and constants for the sprite quad vertex setup block.
// ----------------------------------------------------------------------------
package sqvs_pkg;

  localparam int CordicSteps = 16;
  localparam int DivNumW     = 42;
  localparam int DivDenW     = 17;
  localparam int CountW      = 17;

  typedef enum logic [1:0] {
    KIND_BEGIN  = 2'd0,
    KIND_DRAW   = 2'd1,
    KIND_END    = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    EV_VERTEX = 2'd0,
    EV_FLUSH  = 2'd1,
    EV_ERROR  = 2'd2,
    EV_ACK    = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [CountW-1:0]  vertex_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        depth_out;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [31:0]        colour_out;
    logic               last;
  } rsp_t;

  function automatic logic signed [32:0] atan_turn(input logic [3:0] i);
    logic signed [32:0] a;
    unique case (i)
      4'd0:  a = 33'sd536870912;
      4'd1:  a = 33'sd316933406;
      4'd2:  a = 33'sd167458907;
      4'd3:  a = 33'sd85004756;
      4'd4:  a = 33'sd42667331;
      4'd5:  a = 33'sd21354465;
      4'd6:  a = 33'sd10679838;
      4'd7:  a = 33'sd5340245;
      4'd8:  a = 33'sd2670163;
      4'd9:  a = 33'sd1335087;
      4'd10: a = 33'sd667544;
      4'd11: a = 33'sd333772;
      4'd12: a = 33'sd166886;
      4'd13: a = 33'sd83443;
      4'd14: a = 33'sd41722;
      default: a = 33'sd20861;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ sv/sqvs_req_if.sv @@
// ----------------------------------------------------------------------------
// sqvs_req_if
// Request channel: one sprite command per handshake.
// ----------------------------------------------------------------------------
interface sqvs_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] texture_tag;
  logic [31:0] texture_dims;
  logic [31:0] src_pos;
  logic [31:0] src_dims;
  logic [31:0] dst_pos;
  logic [31:0] dst_dims;
  logic [31:0] tint;
  logic [15:0] angle;
  logic [47:0] pivot;
  logic [1:0]  flip_bits;
  logic [15:0] layer_depth;

  modport source (output valid, kind, texture_tag, texture_dims, src_pos, src_dims,
                  dst_pos, dst_dims, tint, angle, pivot, flip_bits, layer_depth,
                  input ready);
  modport sink   (input valid, kind, texture_tag, texture_dims, src_pos, src_dims,
                  dst_pos, dst_dims, tint, angle, pivot, flip_bits, layer_depth,
                  output ready);
endinterface

@@ sv/sqvs_rsp_if.sv @@
// ----------------------------------------------------------------------------
// sqvs_rsp_if
// Result channel: vertices, flush markers, errors and acknowledges.
// ----------------------------------------------------------------------------
interface sqvs_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_res;
  logic [16:0]        vertex_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        depth_out;
  logic signed [31:0] tex_u;
  logic signed [31:0] tex_v;
  logic [31:0]        colour_out;
  logic               last;

  modport source (output valid, event_res, vertex_index, pos_x, pos_y, depth_out,
                  tex_u, tex_v, colour_out, last, input ready);
  modport sink   (input valid, event_res, vertex_index, pos_x, pos_y, depth_out,
                  tex_u, tex_v, colour_out, last, output ready);
endinterface

@@ sv/sqvs_div.sv @@
// ----------------------------------------------------------------------------
// sqvs_div
// Restoring signed divider, one quotient bit per cycle, truncating toward
// zero, saturated to 32 bits; divide by zero saturates by numerator sign.
// ----------------------------------------------------------------------------
module sqvs_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [sqvs_pkg::DivNumW-1:0] num,
  input  logic signed [sqvs_pkg::DivDenW-1:0] den,
  output logic                               done,
  output logic signed [31:0]                 quo
);
  import sqvs_pkg::*;

  localparam logic [5:0] Steps = 6'(DivNumW);

  logic [5:0]          cnt;
  logic                busy;
  logic [DivNumW-1:0]  qreg;
  logic [DivDenW-1:0]  rem;
  logic [DivDenW-1:0]  dmag;
  logic                neg;
  logic                nsign;
  logic                nzero;
  logic                dzero;
  logic [DivDenW:0]    rem_sh;
  logic                qbit;
  logic [DivDenW:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem, qreg[DivNumW-1]};
    rem_sub = rem_sh - {1'b0, dmag};
    qbit    = (rem_sh >= {1'b0, dmag});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= Steps;
        rem   <= '0;
        qreg  <= num[DivNumW-1] ? DivNumW'(-num) : DivNumW'(num);
        dmag  <= den[DivDenW-1] ? DivDenW'(-den) : DivDenW'(den);
        neg   <= num[DivNumW-1] ^ den[DivDenW-1];
        nsign <= num[DivNumW-1];
        nzero <= (num == '0);
        dzero <= (den == '0);
      end else if (busy) begin
        rem  <= qbit ? rem_sub[DivDenW-1:0] : rem_sh[DivDenW-1:0];
        qreg <= {qreg[DivNumW-2:0], qbit};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (dzero) begin
      if (nzero) quo = '0;
      else if (nsign) quo = 32'sh80000000;
      else quo = 32'sh7FFFFFFF;
    end else if (neg) begin
      if (qreg > DivNumW'(64'h80000000)) quo = 32'sh80000000;
      else quo = 32'(-qreg);
    end else begin
      if (qreg > DivNumW'(64'h7FFFFFFF)) quo = 32'sh7FFFFFFF;
      else quo = qreg[31:0];
    end
  end

endmodule

@@ sv/sqvs_cordic.sv @@
// ----------------------------------------------------------------------------
// sqvs_cordic
// Iterative CORDIC: quarter-turn fold, 16 rotation steps, Q1.30 sin/cos.
// ----------------------------------------------------------------------------
module sqvs_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               valid,
  output logic signed [31:0] cs,
  output logic signed [31:0] sn
);
  import sqvs_pkg::*;

  localparam logic [31:0] PhMask = 32'hFFFFFFFF << (32 - ANGLE_BITS);
  localparam logic signed [33:0] Gain = 34'sd652032874;
  localparam logic signed [33:0] One  = 34'sd1073741824;

  logic [31:0]        phase;
  logic [31:0]        phase_rnd;
  logic [1:0]         q_in;
  logic [31:0]        r_in;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [32:0] z;
  logic [1:0]         q;
  logic [3:0]         step;
  logic               busy;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [32:0] at;
  logic signed [33:0] c_full;
  logic signed [33:0] s_full;

  always_comb begin
    phase     = {angle, 16'h0000} & PhMask;
    phase_rnd = phase + 32'h20000000;
    q_in      = phase_rnd[31:30];
    r_in      = phase - {q_in, 30'h0};
    xs        = x >>> step;
    ys        = y >>> step;
    at        = atan_turn(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      step  <= '0;
    end else if (start) begin
      q     <= q_in;
      step  <= '0;
      z     <= 33'(signed'(r_in));
      valid <= 1'b0;
      if (r_in == 32'h0) begin
        x     <= One;
        y     <= '0;
        busy  <= 1'b0;
        valid <= 1'b1;
      end else begin
        x    <= Gain;
        y    <= '0;
        busy <= 1'b1;
      end
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      step <= step + 4'd1;
      if (step == 4'(CordicSteps - 1)) begin
        busy  <= 1'b0;
        valid <= 1'b1;
      end
    end
  end

  always_comb begin
    unique case (q)
      2'd0: begin c_full = x;  s_full = y;  end
      2'd1: begin c_full = -y; s_full = x;  end
      2'd2: begin c_full = -x; s_full = -y; end
      default: begin c_full = y; s_full = -x; end
    endcase
    cs = c_full[31:0];
    sn = s_full[31:0];
  end

endmodule

@@ sv/sprite_quad_vertex_setup.sv @@
// ----------------------------------------------------------------------------
// sprite_quad_vertex_setup
// Sprite batch command processor: begin/draw/end, quad vertex generation.
//
//   channel | dir | handshake   | carries
//   req     | in  | valid/ready | one command request (begin, draw, end)
//   rsp     | out | valid/ready | one vertex, flush, error or acknowledge
//
// Draw: 8 divisions on one shared divider with CORDIC in parallel, then
// rotation on one 32x32 multiplier, then up to 5 results. Begin/end/error
// give one result each. req.ready is low while a request is in work; rsp
// is a register, stalls hold it.
// Reset (rst, synchronous): batch closed, no pending vertices.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_setup #(
  parameter int MAX_BATCH_VERTICES = 65536,
  parameter int ANGLE_BITS         = 16
) (
  input  logic        clk,
  input  logic        rst,
  sqvs_req_if.sink    req,
  sqvs_rsp_if.source  rsp
);
  import sqvs_pkg::*;

  localparam logic [CountW:0] MaxVerts = (CountW+1)'(MAX_BATCH_VERTICES);

  state_t state, state_next;

  logic              batch_open;
  logic [CountW-1:0] pending_count;
  logic [15:0]       current_tag;
  logic              tag_valid;

  logic [31:0] tdims, spos, sdims, dpos, ddims, tint_r;
  logic [47:0] pivot_r;
  logic [1:0]  flip_r;
  logic [15:0] depth_r;

  logic              single;
  logic [1:0]        single_ev;
  logic [CountW-1:0] single_idx;
  logic              do_flush;
  logic [CountW-1:0] flush_cnt;
  logic [CountW-1:0] base_idx;
  logic [2:0]        emit_idx;

  logic [2:0]  div_idx;
  logic        div_go;
  logic        div_start;
  logic        div_done;
  logic signed [31:0] div_quo;
  logic signed [DivNumW-1:0] div_num;
  logic signed [DivDenW-1:0] div_den;
  logic signed [31:0] qres [8];

  logic        cord_start;
  logic        cord_valid;
  logic signed [31:0] cs, sn;

  logic [4:0]  mcnt;
  logic signed [63:0] prod;
  logic signed [65:0] acc;
  logic signed [31:0] rxv [4];
  logic signed [31:0] ryv [4];

  logic        accept;
  logic        draw_ok;
  logic        out_load;
  rsp_t        out_reg, out_next;

  assign accept   = req.valid && req.ready;
  assign draw_ok  = (kind_t'(req.kind) == KIND_DRAW) && batch_open;
  assign out_load = !rsp.valid || rsp.ready;

  // ---------------- next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (draw_ok) state_next = ST_DIV;
          else if (kind_t'(req.kind) != KIND_UNUSED) state_next = ST_EMIT;
        end
      end
      ST_DIV:  if (div_done && div_idx == 3'd7) state_next = ST_MUL;
      ST_MUL:  if (mcnt == 5'd16) state_next = ST_EMIT;
      ST_EMIT: if (out_load && (single || emit_idx == 3'd4)) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- control outputs
  always_comb begin
    req.ready  = (state == ST_IDLE);
    div_start  = (state == ST_DIV) && div_go;
    cord_start = (state == ST_IDLE) && accept && draw_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // ---------------- divider operands
  logic signed [15:0] sx, sy, sw, sh, dw, dh;
  logic signed [23:0] ox, oy;
  logic signed [24:0] cnum_a;
  logic signed [15:0] cnum_b;
  logic signed [40:0] cprod;

  always_comb begin
    sx = spos[31:16];  sy = spos[15:0];
    sw = sdims[31:16]; sh = sdims[15:0];
    dw = ddims[31:16]; dh = ddims[15:0];
    ox = pivot_r[47:24]; oy = pivot_r[23:0];
    unique case (div_idx)
      3'd4:    begin cnum_a = -25'(ox); cnum_b = dw; end
      3'd5:    begin cnum_a = 25'(signed'({sw, 8'h00})) - 25'(ox); cnum_b = dw; end
      3'd6:    begin cnum_a = -25'(oy); cnum_b = dh; end
      default: begin cnum_a = 25'(signed'({sh, 8'h00})) - 25'(oy); cnum_b = dh; end
    endcase
    cprod = cnum_a * cnum_b;
    unique case (div_idx)
      3'd0: begin div_num = DivNumW'(signed'({sx, 16'h0})); div_den = {1'b0, tdims[31:16]}; end
      3'd1: begin div_num = DivNumW'(signed'({sy, 16'h0})); div_den = {1'b0, tdims[15:0]}; end
      3'd2: begin div_num = DivNumW'(signed'({sw, 16'h0})); div_den = {1'b0, tdims[31:16]}; end
      3'd3: begin div_num = DivNumW'(signed'({sh, 16'h0})); div_den = {1'b0, tdims[15:0]}; end
      3'd4, 3'd5: begin div_num = DivNumW'(cprod); div_den = DivDenW'(sw); end
      default:    begin div_num = DivNumW'(cprod); div_den = DivDenW'(sh); end
    endcase
  end

  sqvs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  sqvs_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .angle (req.angle),
    .valid (cord_valid),
    .cs    (cs),
    .sn    (sn)
  );

  // ---------------- texture coordinates
  logic signed [31:0] u1, v1, u2, v2, tu_lo, tu_hi, tv_lo, tv_hi;
  always_comb begin
    u1 = qres[0];
    v1 = qres[1];
    u2 = sat32(37'(u1) + 37'(qres[2]));
    v2 = sat32(37'(v1) + 37'(qres[3]));
    tu_lo = flip_r[0] ? u2 : u1;
    tu_hi = flip_r[0] ? u1 : u2;
    tv_lo = flip_r[1] ? v2 : v1;
    tv_hi = flip_r[1] ? v1 : v2;
  end

  // ---------------- rotation multiply
  logic [1:0]  mk;
  logic [1:0]  mt;
  logic signed [31:0] ma, mb;
  logic [1:0]  pk;
  logic [1:0]  pt;
  logic signed [65:0] sum;
  logic signed [35:0] rot;
  logic signed [36:0] fin;
  logic signed [15:0] dxs, dys;

  always_comb begin
    mk = mcnt[3:2];
    mt = mcnt[1:0];
    pk = 2'((mcnt - 5'd1) >> 2);
    pt = 2'(mcnt - 5'd1);
    unique case (mt)
      2'd0: begin ma = (mk == 2'd1 || mk == 2'd2) ? qres[5] : qres[4]; mb = cs; end
      2'd1: begin ma = mk[1] ? qres[7] : qres[6]; mb = sn; end
      2'd2: begin ma = (mk == 2'd1 || mk == 2'd2) ? qres[5] : qres[4]; mb = sn; end
      default: begin ma = mk[1] ? qres[7] : qres[6]; mb = cs; end
    endcase
    dxs = dpos[31:16];
    dys = dpos[15:0];
    if (pt == 2'd1) sum = acc - 66'(prod);
    else sum = acc + 66'(prod);
    rot = 36'((sum + 66'sd536870912) >>> 30);
    fin = 37'(signed'({pt[1] ? dys : dxs, 8'h00})) + 37'(rot);
  end

  // ---------------- result assembly
  logic [1:0] vk;
  always_comb begin
    vk = 2'(emit_idx - 3'd1);
    out_next = '0;
    if (single) begin
      out_next.event_res    = single_ev;
      out_next.vertex_index = single_idx;
      out_next.last         = 1'b1;
    end else if (emit_idx == 3'd0) begin
      out_next.event_res    = EV_FLUSH;
      out_next.vertex_index = flush_cnt;
    end else begin
      out_next.event_res    = EV_VERTEX;
      out_next.vertex_index = base_idx + CountW'(vk);
      out_next.pos_x        = rxv[vk];
      out_next.pos_y        = ryv[vk];
      out_next.depth_out    = depth_r;
      out_next.tex_u        = (vk == 2'd1 || vk == 2'd2) ? tu_hi : tu_lo;
      out_next.tex_v        = vk[1] ? tv_hi : tv_lo;
      out_next.colour_out   = tint_r;
      out_next.last         = (emit_idx == 3'd4);
    end
  end

  // ---------------- batch state and datapath
  logic flush_now;
  logic [CountW:0] pend_plus;
  always_comb begin
    pend_plus = {1'b0, pending_count} + (CountW+1)'(4);
    flush_now = tag_valid && (pending_count != '0) &&
                ((req.texture_tag != current_tag) || (pend_plus > MaxVerts));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      batch_open    <= 1'b0;
      pending_count <= '0;
      current_tag   <= '0;
      tag_valid     <= 1'b0;
      rsp.valid     <= 1'b0;
      div_go        <= 1'b0;
    end else begin
      if (state == ST_IDLE && accept) begin
        unique case (kind_t'(req.kind))
          KIND_BEGIN: begin
            batch_open <= 1'b1;
            single     <= 1'b1;
            single_ev  <= EV_ACK;
            single_idx <= '0;
          end
          KIND_END: begin
            batch_open <= 1'b0;
            single     <= 1'b1;
            if (pending_count != '0) begin
              single_ev     <= EV_FLUSH;
              single_idx    <= pending_count;
              pending_count <= '0;
              tag_valid     <= 1'b0;
            end else begin
              single_ev  <= EV_ACK;
              single_idx <= '0;
            end
          end
          KIND_DRAW: begin
            if (!batch_open) begin
              single     <= 1'b1;
              single_ev  <= EV_ERROR;
              single_idx <= '0;
            end else begin
              single      <= 1'b0;
              do_flush    <= flush_now;
              flush_cnt   <= pending_count;
              base_idx    <= flush_now ? '0 : pending_count;
              pending_count <= flush_now ? CountW'(4) : pend_plus[CountW-1:0];
              current_tag <= req.texture_tag;
              tag_valid   <= 1'b1;
              div_go      <= 1'b1;
            end
          end
          default: ;
        endcase
        div_idx <= '0;
        tdims   <= req.texture_dims;
        spos    <= req.src_pos;
        sdims   <= req.src_dims;
        dpos    <= req.dst_pos;
        ddims   <= req.dst_dims;
        tint_r  <= req.tint;
        pivot_r <= req.pivot;
        flip_r  <= req.flip_bits;
        depth_r <= req.layer_depth;
        emit_idx <= (draw_ok && !flush_now) ? 3'd1 : 3'd0;
        mcnt    <= '0;
      end
      if (div_start) div_go <= 1'b0;
      if (state == ST_DIV && div_done) begin
        qres[div_idx] <= div_quo;
        if (div_idx != 3'd7) begin
          div_idx <= div_idx + 3'd1;
          div_go  <= 1'b1;
        end
      end
      if (state == ST_MUL) begin
        mcnt <= mcnt + 5'd1;
        if (mcnt != 5'd16) prod <= ma * mb;
        if (mcnt != 5'd0) begin
          if (pt == 2'd0 || pt == 2'd2) acc <= 66'(prod);
          else if (pt == 2'd1) rxv[pk] <= sat32(fin);
          else ryv[pk] <= sat32(fin);
        end
      end
      if (state == ST_EMIT && out_load) begin
        out_reg   <= out_next;
        rsp.valid <= 1'b1;
        emit_idx  <= emit_idx + 3'd1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  assign rsp.event_res    = out_reg.event_res;
  assign rsp.vertex_index = out_reg.vertex_index;
  assign rsp.pos_x        = out_reg.pos_x;
  assign rsp.pos_y        = out_reg.pos_y;
  assign rsp.depth_out    = out_reg.depth_out;
  assign rsp.tex_u        = out_reg.tex_u;
  assign rsp.tex_v        = out_reg.tex_v;
  assign rsp.colour_out   = out_reg.colour_out;
  assign rsp.last         = out_reg.last;

`ifndef SYNTHESIS
  a_cordic_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> cord_valid)
    else $error("rotation started before sine/cosine ready");
  a_pending_quad: assert property (@(posedge clk) disable iff (rst)
    pending_count[1:0] == 2'b00)
    else $error("pending vertex count not a multiple of four");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside divide phase");
  a_flush_first: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !single && emit_idx == 3'd0) |-> do_flush)
    else $error("flush emitted without a flush request");
`endif

endmodule
